### hdl/gcd_pkg.sv
// Shared types, constants and arc tangent table for the angular distance pipeline.
package gcd_pkg;

    localparam int ROT_STEPS  = 30;
    localparam int SQRT_STEPS = 31;
    localparam int VEC_STEPS  = 30;

    // CORDIC datapath widths: x/y carry growth headroom, z holds up to about 1.75 rad in Q.30
    localparam int XW = 34;
    localparam int ZW = 33;

    localparam logic signed [35:0] ONE_Q30     = 36'sd1073741824;
    localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
    localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
    localparam logic signed [XW-1:0] GAIN_Q30  = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] ra_first;
        logic signed [31:0] dec_first;
        logic signed [31:0] ra_second;
        logic signed [31:0] dec_second;
        logic               last_pair;
    } t_in;

    typedef struct packed {
        logic [31:0] separation;
        logic        last_out;
    } t_out;

    // Sideband that travels with each transaction down the pipeline
    typedef struct packed {
        logic       vld;
        logic       last;
        logic [2:0] neg;
        logic       csgn;
    } t_tag;

    function automatic logic [30:0] f_atan(input int i);
        case (i)
            0:       f_atan = 31'd843314857;
            1:       f_atan = 31'd497837829;
            2:       f_atan = 31'd263043837;
            3:       f_atan = 31'd133525158;
            4:       f_atan = 31'd67021687;
            5:       f_atan = 31'd33543516;
            6:       f_atan = 31'd16775851;
            7:       f_atan = 31'd8388437;
            8:       f_atan = 31'd4194283;
            9:       f_atan = 31'd2097149;
            default: f_atan = 31'd1 << (30 - i);
        endcase
    endfunction

endpackage

### hdl/gcd_rot_cell.sv
// One rotation-mode CORDIC step for the three sine/cosine lanes.
module gcd_rot_cell #(
    parameter int STEP = 0
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  gcd_pkg::t_tag                     i_tag,
    input  logic signed [gcd_pkg::XW-1:0]     i_x [3],
    input  logic signed [gcd_pkg::XW-1:0]     i_y [3],
    input  logic signed [gcd_pkg::ZW-1:0]     i_z [3],
    output gcd_pkg::t_tag                     o_tag,
    output logic signed [gcd_pkg::XW-1:0]     o_x [3],
    output logic signed [gcd_pkg::XW-1:0]     o_y [3],
    output logic signed [gcd_pkg::ZW-1:0]     o_z [3]
);
    import gcd_pkg::*;

    logic signed [ZW-1:0] w_atan;
    t_tag                 r_tag;
    logic signed [XW-1:0] r_x [3];
    logic signed [XW-1:0] r_y [3];
    logic signed [ZW-1:0] r_z [3];
    logic signed [XW-1:0] n_x [3];
    logic signed [XW-1:0] n_y [3];
    logic signed [ZW-1:0] n_z [3];

    assign w_atan = $signed({2'b00, f_atan(STEP)});

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_z[k][ZW-1]) begin
                n_x[k] = i_x[k] - (i_y[k] >>> STEP);
                n_y[k] = i_y[k] + (i_x[k] >>> STEP);
                n_z[k] = i_z[k] - w_atan;
            end else begin
                n_x[k] = i_x[k] + (i_y[k] >>> STEP);
                n_y[k] = i_y[k] - (i_x[k] >>> STEP);
                n_z[k] = i_z[k] + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### hdl/gcd_sqrt_cell.sv
// One bit of the restoring integer square root of 1 - c*c.
module gcd_sqrt_cell #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  gcd_pkg::t_tag i_tag,
    input  logic [60:0]   i_rem,
    input  logic [61:0]   i_root,
    input  logic [30:0]   i_mag,
    output gcd_pkg::t_tag o_tag,
    output logic [60:0]   o_rem,
    output logic [61:0]   o_root,
    output logic [30:0]   o_mag
);
    import gcd_pkg::*;

    localparam logic [61:0] BIT = 62'd1 << (2 * K);

    logic [61:0] w_trial;
    logic [60:0] n_rem;
    logic [61:0] n_root;
    t_tag        r_tag;
    logic [60:0] r_rem;
    logic [61:0] r_root;
    logic [30:0] r_mag;

    assign w_trial = i_root + BIT;

    always_comb begin
        if ({1'b0, i_rem} >= w_trial) begin
            n_rem  = i_rem - w_trial[60:0];
            n_root = (i_root >> 1) + BIT;
        end else begin
            n_rem  = i_rem;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_mag  <= i_mag;
        end
    end

    assign o_tag  = r_tag;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_mag  = r_mag;

endmodule

### hdl/gcd_vec_cell.sv
// One vectoring-mode CORDIC step of the arc tangent.
module gcd_vec_cell #(
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  gcd_pkg::t_tag                 i_tag,
    input  logic signed [gcd_pkg::XW-1:0] i_x,
    input  logic signed [gcd_pkg::XW-1:0] i_y,
    input  logic signed [gcd_pkg::ZW-1:0] i_z,
    output gcd_pkg::t_tag                 o_tag,
    output logic signed [gcd_pkg::XW-1:0] o_x,
    output logic signed [gcd_pkg::XW-1:0] o_y,
    output logic signed [gcd_pkg::ZW-1:0] o_z
);
    import gcd_pkg::*;

    logic signed [ZW-1:0] w_atan;
    logic signed [XW-1:0] n_x;
    logic signed [XW-1:0] n_y;
    logic signed [ZW-1:0] n_z;
    t_tag                 r_tag;
    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [ZW-1:0] r_z;

    assign w_atan = $signed({2'b00, f_atan(STEP)});

    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + w_atan;
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_en) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_tag = r_tag;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### hdl/great_circle_distance.sv
// Angular separation of two sky positions: fully pipelined, one pair accepted per clock
// while the output is not stalled; each pair passes through 3 reduction stages, 30 rotation
// CORDIC cells for the three sines and cosines, 1 clamp stage, 4 multiply stages,
// 2 square stages, 31 square-root cells, 30 vectoring CORDIC cells and the output
// register. The whole pipeline holds while a result waits to be taken, so i_ready low
// stalls the input side in the same cycle; there is no reset sweep or other dead time.
module great_circle_distance (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  gcd_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output gcd_pkg::t_out o_data
);
    import gcd_pkg::*;

    localparam logic signed [35:0] THREE_PI   = 36'sd10119778278;
    localparam logic signed [35:0] FIVE_PI    = 36'sd16866297130;
    localparam logic signed [35:0] FOUR_PI    = 36'sd13493037704;
    localparam logic signed [35:0] SIX_PI     = 36'sd20239556556;
    localparam logic signed [63:0] HALF_LSB   = 64'sd536870912;
    localparam logic [61:0]        ONE_SQ     = 62'd1 << 60;

    function automatic logic signed [31:0] f_sat(input logic signed [XW-1:0] v);
        if (v > ONE_Q30) begin
            f_sat = 32'(ONE_Q30);
        end else if (v < -ONE_Q30) begin
            f_sat = 32'(-ONE_Q30);
        end else begin
            f_sat = 32'(v);
        end
    endfunction

    logic                 w_en;

    // reduction stages
    t_tag                 r_tag1;
    logic signed [35:0]   r_ang1 [3];
    t_tag                 r_tag2;
    logic signed [35:0]   r_ang2 [3];
    logic signed [35:0]   n_ang2 [3];
    t_tag                 r_tag3;
    logic signed [ZW-1:0] r_ang3 [3];
    logic signed [ZW-1:0] n_ang3 [3];
    logic [2:0]           n_neg;

    // rotation chain
    t_tag                 w_rtag [ROT_STEPS+1];
    logic signed [XW-1:0] w_rx   [ROT_STEPS+1][3];
    logic signed [XW-1:0] w_ry   [ROT_STEPS+1][3];
    logic signed [ZW-1:0] w_rz   [ROT_STEPS+1][3];

    // products
    t_tag                 r_tagk;
    logic signed [31:0]   r_sin [3];
    logic signed [31:0]   r_cos [3];
    t_tag                 r_tagm1;
    logic signed [63:0]   r_pss1;
    logic signed [63:0]   r_pcc1;
    logic signed [31:0]   r_cr1;
    t_tag                 r_tagm2;
    logic signed [63:0]   r_pss2;
    logic signed [31:0]   r_cc2;
    logic signed [31:0]   r_cr2;
    logic signed [63:0]   w_cc_rnd;
    t_tag                 r_tagm3;
    logic signed [63:0]   r_pss3;
    logic signed [63:0]   r_pccr3;
    t_tag                 r_tagm4;
    logic [30:0]          r_mag4;
    logic signed [63:0]   w_sum;
    logic signed [63:0]   w_dot;
    logic [30:0]          n_mag4;
    t_tag                 r_tagq1;
    logic [61:0]          r_sq1;
    logic [30:0]          r_mag_q1;
    t_tag                 r_tagq2;
    logic [60:0]          r_n2;
    logic [30:0]          r_mag_q2;

    // square root chain
    t_tag                 w_stag [SQRT_STEPS+1];
    logic [60:0]          w_srem [SQRT_STEPS+1];
    logic [61:0]          w_sroot[SQRT_STEPS+1];
    logic [30:0]          w_smag [SQRT_STEPS+1];

    // vectoring chain
    t_tag                 w_vtag [VEC_STEPS+1];
    logic signed [XW-1:0] w_vx   [VEC_STEPS+1];
    logic signed [XW-1:0] w_vy   [VEC_STEPS+1];
    logic signed [ZW-1:0] w_vz   [VEC_STEPS+1];

    logic signed [ZW-1:0] w_zc;
    logic signed [35:0]   w_sep;
    logic                 r_out_vld;
    t_out                 r_out;

    // advance everything whenever the output register is free or being drained
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // ---------------- stage 1: widen to Q.30, form the RA difference
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else if (w_en) begin
            r_tag1.vld  <= i_valid;
            r_tag1.last <= i_data.last_pair;
            r_tag1.neg  <= '0;
            r_tag1.csgn <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang1[0] <= $signed({{2{i_data.dec_first[31]}}, i_data.dec_first, 2'b00});
            r_ang1[1] <= $signed({{2{i_data.dec_second[31]}}, i_data.dec_second, 2'b00});
            r_ang1[2] <= $signed({{2{i_data.ra_first[31]}}, i_data.ra_first, 2'b00})
                       - $signed({{2{i_data.ra_second[31]}}, i_data.ra_second, 2'b00});
        end
    end

    // ---------------- stage 2: wrap into [-pi, pi]
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_ang2[k] = r_ang1[k];
            if (r_ang1[k] > FIVE_PI) begin
                n_ang2[k] = r_ang1[k] - SIX_PI;
            end else if (r_ang1[k] > THREE_PI) begin
                n_ang2[k] = r_ang1[k] - FOUR_PI;
            end else if (r_ang1[k] > PI_Q30) begin
                n_ang2[k] = r_ang1[k] - TWO_PI_Q30;
            end else if (r_ang1[k] < -FIVE_PI) begin
                n_ang2[k] = r_ang1[k] + SIX_PI;
            end else if (r_ang1[k] < -THREE_PI) begin
                n_ang2[k] = r_ang1[k] + FOUR_PI;
            end else if (r_ang1[k] < -PI_Q30) begin
                n_ang2[k] = r_ang1[k] + TWO_PI_Q30;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else if (w_en) begin
            r_tag2 <= r_tag1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang2 <= n_ang2;
        end
    end

    // ---------------- stage 3: fold into [-pi/2, pi/2], remember the cosine sign flip
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_neg[k]  = 1'b0;
            n_ang3[k] = ZW'(r_ang2[k]);
            if (r_ang2[k] > HALF_PI_Q30) begin
                n_ang3[k] = ZW'(PI_Q30 - r_ang2[k]);
                n_neg[k]  = 1'b1;
            end else if (r_ang2[k] < -HALF_PI_Q30) begin
                n_ang3[k] = ZW'(-PI_Q30 - r_ang2[k]);
                n_neg[k]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag3 <= '0;
        end else if (w_en) begin
            r_tag3     <= r_tag2;
            r_tag3.neg <= n_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang3 <= n_ang3;
        end
    end

    // ---------------- rotation CORDIC chain
    assign w_rtag[0] = r_tag3;
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rx[0][k] = GAIN_Q30;
            w_ry[0][k] = '0;
            w_rz[0][k] = r_ang3[k];
        end
    end

    for (genvar g = 0; g < ROT_STEPS; g++) begin : g_rot
        gcd_rot_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_rtag[g]),
            .i_x    (w_rx[g]),
            .i_y    (w_ry[g]),
            .i_z    (w_rz[g]),
            .o_tag  (w_rtag[g+1]),
            .o_x    (w_rx[g+1]),
            .o_y    (w_ry[g+1]),
            .o_z    (w_rz[g+1])
        );
    end

    // ---------------- clamp and apply the fold sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tagk <= '0;
        end else if (w_en) begin
            r_tagk <= w_rtag[ROT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sin[k] <= f_sat(w_ry[ROT_STEPS][k]);
                r_cos[k] <= w_rtag[ROT_STEPS].neg[k] ? -f_sat(w_rx[ROT_STEPS][k])
                                                      : f_sat(w_rx[ROT_STEPS][k]);
            end
        end
    end

    // ---------------- dot product
    assign w_cc_rnd = (r_pcc1 + HALF_LSB) >>> 30;
    assign w_sum    = r_pss3 + r_pccr3 + HALF_LSB;
    assign w_dot    = w_sum >>> 30;

    always_comb begin
        if (w_dot > 64'(ONE_Q30) || w_dot < -64'(ONE_Q30)) begin
            n_mag4 = 31'(ONE_Q30);
        end else if (w_dot[63]) begin
            n_mag4 = 31'(-w_dot);
        end else begin
            n_mag4 = 31'(w_dot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tagm1   <= '0;
            r_tagm2   <= '0;
            r_tagm3   <= '0;
            r_tagm4   <= '0;
            r_tagq1   <= '0;
            r_tagq2   <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_tagm1        <= r_tagk;
            r_tagm2        <= r_tagm1;
            r_tagm3        <= r_tagm2;
            r_tagm4        <= r_tagm3;
            r_tagm4.csgn   <= w_sum[63];
            r_tagq1        <= r_tagm4;
            r_tagq2        <= r_tagq1;
            r_out_vld      <= w_vtag[VEC_STEPS].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pss1   <= r_sin[0] * r_sin[1];
            r_pcc1   <= r_cos[0] * r_cos[1];
            r_cr1    <= r_cos[2];
            r_pss2   <= r_pss1;
            r_cc2    <= 32'(w_cc_rnd);
            r_cr2    <= r_cr1;
            r_pss3   <= r_pss2;
            r_pccr3  <= r_cc2 * r_cr2;
            r_mag4   <= n_mag4;
            r_sq1    <= 62'(r_mag4) * 62'(r_mag4);
            r_mag_q1 <= r_mag4;
            r_n2     <= 61'(ONE_SQ - r_sq1);
            r_mag_q2 <= r_mag_q1;
        end
    end

    // ---------------- square root chain, one result bit per cell
    assign w_stag[0]  = r_tagq2;
    assign w_srem[0]  = r_n2;
    assign w_sroot[0] = '0;
    assign w_smag[0]  = r_mag_q2;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        gcd_sqrt_cell #(
            .K(SQRT_STEPS - 1 - g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_stag[g]),
            .i_rem  (w_srem[g]),
            .i_root (w_sroot[g]),
            .i_mag  (w_smag[g]),
            .o_tag  (w_stag[g+1]),
            .o_rem  (w_srem[g+1]),
            .o_root (w_sroot[g+1]),
            .o_mag  (w_smag[g+1])
        );
    end

    // ---------------- vectoring CORDIC chain: atan2(sqrt(1 - c*c), |c|)
    assign w_vtag[0] = w_stag[SQRT_STEPS];
    assign w_vx[0]   = $signed({{(XW-31){1'b0}}, w_smag[SQRT_STEPS]});
    assign w_vy[0]   = $signed({{(XW-31){1'b0}}, w_sroot[SQRT_STEPS][30:0]});
    assign w_vz[0]   = '0;

    for (genvar g = 0; g < VEC_STEPS; g++) begin : g_vec
        gcd_vec_cell #(
            .STEP(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_vtag[g]),
            .i_x    (w_vx[g]),
            .i_y    (w_vy[g]),
            .i_z    (w_vz[g]),
            .o_tag  (w_vtag[g+1]),
            .o_x    (w_vx[g+1]),
            .o_y    (w_vy[g+1]),
            .o_z    (w_vz[g+1])
        );
    end

    // ---------------- clamp the angle and mirror for a negative dot product
    always_comb begin
        if (w_vz[VEC_STEPS][ZW-1]) begin
            w_zc = '0;
        end else if (w_vz[VEC_STEPS] > HALF_PI_Q30) begin
            w_zc = ZW'(HALF_PI_Q30);
        end else begin
            w_zc = w_vz[VEC_STEPS];
        end
    end

    assign w_sep = w_vtag[VEC_STEPS].csgn ? (PI_Q30 - w_zc) : 36'(w_zc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.separation <= 32'(w_sep);
            r_out.last_out   <= w_vtag[VEC_STEPS].last;
        end
    end

    // ---------------- checks
    a_sep_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.separation <= 32'd3373259426))
        else $error("separation beyond pi");

    a_dot_clamped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tagm4.vld |-> (r_mag4 <= 31'(ONE_Q30)))
        else $error("dot product magnitude beyond one");

    a_root_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stag[SQRT_STEPS].vld |-> (w_sroot[SQRT_STEPS] <= 62'(ONE_Q30)))
        else $error("square root beyond one");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && r_tagq2.vld) |=> ($stable(r_n2) && $stable(r_tagq2)))
        else $error("pipeline moved during a stall");

endmodule

### bench/tb_great_circle_distance.sv
// Testbench for the angular separation pipeline: fixed-point law-of-cosines predictor and scoreboard.
module tb_great_circle_distance;
    timeunit 1ns;
    timeprecision 1ps;
    import gcd_pkg::*;

    localparam longint Q_ONE     = 64'sd1073741824;
    localparam longint Q_PI      = 64'sd3373259426;
    localparam longint Q_TWO_PI  = 64'sd6746518852;
    localparam longint Q_HALF_PI = 64'sd1686629713;
    localparam longint Q_GAIN    = 64'sd652032874;
    localparam int     N_STEPS   = 30;
    localparam int     PIPE_LAT  = 102;
    localparam longint CYCLE_CAP = 64'd400000;

    function automatic longint arctan_entry(int i);
        longint head [10] = '{843314857, 497837829, 263043837, 133525158, 67021687,
                              33543516, 16775851, 8388437, 4194283, 2097149};
        if (i < 10) return head[i];
        return 64'sd1 << (30 - i);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Rotation CORDIC after reducing the angle into [-pi/2, pi/2]
    function automatic void rotate_angle(longint ang, output longint sn, output longint cs);
        longint r, x, y, z, dx, dy;
        bit     flip;
        r = ang % Q_TWO_PI;
        flip = 0;
        if (r > Q_PI) r -= Q_TWO_PI;
        if (r < -Q_PI) r += Q_TWO_PI;
        if (r > Q_HALF_PI) begin
            r = Q_PI - r;
            flip = 1;
        end else if (r < -Q_HALF_PI) begin
            r = -Q_PI - r;
            flip = 1;
        end
        x = Q_GAIN;
        y = 0;
        z = r;
        for (int i = 0; i < N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_entry(i);
            end else begin
                x += dx; y -= dy; z += arctan_entry(i);
            end
        end
        sn = clip(y, -Q_ONE, Q_ONE);
        cs = clip(x, -Q_ONE, Q_ONE);
        if (flip) cs = -cs;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned rem, root, b;
        rem = n;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic longint arccos_q30(longint c);
        longint mag, x, y, z, dx, dy;
        mag = c < 0 ? -c : c;
        x = mag;
        y = int_sqrt(longint'(Q_ONE * Q_ONE - mag * mag));
        z = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_entry(i);
            end else begin
                x -= dx; y += dy; z -= arctan_entry(i);
            end
        end
        z = clip(z, 0, Q_HALF_PI);
        return c < 0 ? Q_PI - z : z;
    endfunction

    function automatic t_out predict_separation(t_in p);
        longint a1, d1, a2, d2, s1, c1, s2, c2, sr, cr, cc, dot;
        t_out r;
        a1 = longint'(p.ra_first) * 4;
        d1 = longint'(p.dec_first) * 4;
        a2 = longint'(p.ra_second) * 4;
        d2 = longint'(p.dec_second) * 4;
        rotate_angle(d1, s1, c1);
        rotate_angle(d2, s2, c2);
        rotate_angle(a1 - a2, sr, cr);
        cc = (c1 * c2 + (64'sd1 << 29)) >>> 30;
        dot = (s1 * s2 + cc * cr + (64'sd1 << 29)) >>> 30;
        dot = clip(dot, -Q_ONE, Q_ONE);
        r.separation = 32'(arccos_q30(dot));
        r.last_out = p.last_pair;
        return r;
    endfunction

    class separation_board;
        t_out pending[$];
        int   n_errors;
        int   n_checked;

        function void note_pair(t_in p);
            pending.push_back(predict_separation(p));
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result sep=%0d last=%0d", $time,
                         got.separation, got.last_out);
                n_errors++;
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.separation !== want.separation) begin
                $display("%0t: separation expected %0d actual %0d", $time,
                         want.separation, got.separation);
                n_errors++;
            end
            if (got.last_out !== want.last_out) begin
                $display("%0t: last_out expected %0d actual %0d", $time,
                         want.last_out, got.last_out);
                n_errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    t_in  i_data;
    t_out o_data;

    great_circle_distance u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    separation_board board;
    int     send_idle_pct;
    int     recv_idle_pct;
    bit     hold_off;
    longint cycle_count;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP) begin
                $display("tb_great_circle_distance: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when requested
    initial begin
        i_ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) board.check_result(o_data);
            if (hold_off) i_ready <= 0;
            else i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [31:0] pick_angle();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'sh8000_0000 + $urandom_range(255);
            2: return 32'sh7FFF_FFFF - $urandom_range(255);
            default: return $signed($urandom_range(843314857)) - 32'sd421657428;
        endcase
    endfunction

    task automatic send_pair(t_in p);
        i_valid <= 1;
        i_data <= p;
        do @(posedge i_clk); while (!o_ready);
        board.note_pair(p);
        // drop valid when the sender idles
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_random(int n);
        t_in p;
        repeat (n) begin
            p.ra_first = pick_angle();
            p.dec_first = pick_angle();
            p.ra_second = pick_angle();
            p.dec_second = pick_angle();
            p.last_pair = $urandom_range(1);
            send_pair(p);
        end
    endtask

    task automatic send_fixed(logic [31:0] a1, logic [31:0] d1, logic [31:0] a2,
                              logic [31:0] d2, logic l);
        t_in p;
        p.ra_first = a1;
        p.dec_first = d1;
        p.ra_second = a2;
        p.dec_second = d2;
        p.last_pair = l;
        send_pair(p);
    endtask

    initial begin
        board = new();
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_valid = 0;
        i_data = '0;
        i_rst_n = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Same point, antipodes, poles, extreme codes, huge angles that wrap
        send_fixed(0, 0, 0, 0, 0);
        send_fixed(0, 0, 32'd843314857, 0, 1);
        send_fixed(0, 32'd421657428, 0, -32'sd421657428, 0);
        send_fixed(0, 32'd421657428, 0, 32'd421657428, 0);
        send_fixed(32'd100000, 32'd5000, 32'd100000, 32'd5000, 1);
        send_fixed(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        send_fixed(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1);
        send_fixed(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        send_fixed(32'd1, 0, 0, 32'd1, 0);
        send_fixed(32'd843314857, 32'd210828714, 0, -32'sd210828714, 0);
        send_fixed(32'd421657428, 0, 0, 0, 0);
        send_fixed(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1);
        send_fixed(0, 32'd421657427, 32'd3, 32'd421657427, 0);

        send_idle_pct = 9;
        recv_idle_pct = 77;
        send_random(450);

        // Hold the receiver off long enough for the pipeline to fill and stall the input
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            send_random(200);
        join

        send_idle_pct = 77;
        recv_idle_pct = 9;
        send_random(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(400);
        i_valid <= 0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 20) @(posedge i_clk);
        $display("Checked %0d separations: poles, antipodes, wrapped extreme angles,",
                 board.n_checked);
        $display("random pairs under sender/receiver stalls and a long output hold-off.");
        if (board.n_errors == 0) $display("tb_great_circle_distance: clean");
        else $display("tb_great_circle_distance: errors");
        $finish;
    end
endmodule
